@@ rtl/chs_pkg.sv @@
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants for the chained hash set
// Pool and bucket sizes, the hash multiplier, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package chs_pkg;
	localparam int BUCKETS    = 256;
	localparam int POOL_DEPTH = 1024;
	localparam int SLOT_W     = 10;
	localparam int BKT_W      = 8;
	localparam int CNT_W      = 9;
	localparam int KEY_W      = 64;
	localparam logic [31:0] HASH_MUL = 32'd2654435761;

	typedef enum logic [1:0] {
		CMD_FIND   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_SPARE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DUP    = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;
endpackage
`default_nettype wire

@@ rtl/chained_hash_set_with_free_list.sv @@
// Flow: one request at a time; the next is accepted only once the result of
//   the last is posted. The chain walk is longer on a miss than on a hit, and
//   insert or remove adds bookkeeping states; the bit-serial bucket remainder
//   in the hash unit takes most of the time.
// Reset: bucket heads read as empty through per-bucket valid bits, free list
//   empty, pool unused, bucket count 256. Pool memories are not cleared.
// ----------------------------------------------------------------------------
// chained_hash_set_with_free_list: hash set of 64-bit keys
// Sequencer walking bucket chains in a node pool with a free list.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_set_with_free_list
	import chs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CNT_W-1:0]  cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        cmd,
	input  wire logic [KEY_W-1:0]  key,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [SLOT_W-1:0]      slot,
	output logic                   found,
	output logic [1:0]             status
);
	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_HASH = 13'b0000000000010,
		S_HRD  = 13'b0000000000100,
		S_HWT  = 13'b0000000001000,
		S_NRD  = 13'b0000000010000,
		S_NCMP = 13'b0000000100000,
		S_ACT  = 13'b0000001000000,
		S_FRD  = 13'b0000010000000,
		S_FWT  = 13'b0000100000000,
		S_INS  = 13'b0001000000000,
		S_REM1 = 13'b0010000000000,
		S_REM2 = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  bc_q;
	logic [CNT_W-1:0]  n_eff;
	cmd_t              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [BKT_W-1:0]  b_q;
	logic [SLOT_W-1:0] head_q, idx_q, prev_q, hit_q, hitlink_q, fresh_q;
	logic [SLOT_W-1:0] free_head_q, hw_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_found_q;
	status_t           res_status_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_found_q;
	status_t           out_status_q;

	logic              accept;
	logic              hash_done;
	logic [BKT_W-1:0]  hash_bucket;

	logic [SLOT_W-1:0] heads_mem [BUCKETS];
	logic [BUCKETS-1:0] hv_q;
	logic [SLOT_W-1:0] head_rd_q;
	logic              h_we;
	logic [SLOT_W-1:0] h_wd;

	logic [KEY_W-1:0]  keys_mem  [POOL_DEPTH];
	logic [SLOT_W-1:0] links_mem [POOL_DEPTH];
	logic [KEY_W-1:0]  key_rd_q;
	logic [SLOT_W-1:0] link_rd_q;
	logic [SLOT_W-1:0] n_ra;
	logic              l_we;
	logic [SLOT_W-1:0] l_wa, l_wd;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		if (bc_q == '0) n_eff = CNT_W'(1);
		else if (bc_q > CNT_W'(BUCKETS)) n_eff = CNT_W'(BUCKETS);
		else n_eff = bc_q;
	end

	chs_hash u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.key     (key),
		.divisor (n_eff),
		.done    (hash_done),
		.bucket  (hash_bucket)
	);

	// memory port control
	assign n_ra = (state_q == S_FRD) ? free_head_q : idx_q;

	always_comb begin
		h_we = 1'b0;
		h_wd = fresh_q;
		l_we = 1'b0;
		l_wa = fresh_q;
		l_wd = head_q;
		unique case (state_q)
			S_INS: begin
				h_we = 1'b1;
				l_we = 1'b1;
			end
			S_REM1: begin
				if (prev_q == '0) begin
					h_we = 1'b1;
					h_wd = hitlink_q;
				end else begin
					l_we = 1'b1;
					l_wa = prev_q;
					l_wd = hitlink_q;
				end
			end
			S_REM2: begin
				l_we = 1'b1;
				l_wa = hit_q;
				l_wd = free_head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (h_we) heads_mem[b_q] <= h_wd;
		head_rd_q <= heads_mem[b_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_INS) keys_mem[fresh_q] <= key_q;
		if (l_we) links_mem[l_wa] <= l_wd;
		key_rd_q  <= keys_mem[n_ra];
		link_rd_q <= links_mem[n_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bc_q        <= CNT_W'(BUCKETS);
			hv_q        <= '0;
			free_head_q <= '0;
			hw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) bc_q <= cfg_wdata;
			if (h_we) hv_q[b_q] <= 1'b1;
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_HASH;
				S_HASH: if (hash_done) state_q <= S_HRD;
				S_HRD:  state_q <= S_HWT;
				S_HWT:  state_q <= S_NRD;
				S_NRD:  state_q <= (idx_q == '0) ? S_ACT : S_NCMP;
				S_NCMP: state_q <= (key_rd_q == key_q) ? S_ACT : S_NRD;
				S_ACT: begin
					priority case (cmd_q)
						CMD_INSERT: begin
							if (hit_q != '0) state_q <= S_DONE;
							else if (free_head_q != '0) state_q <= S_FRD;
							else if (hw_q != SLOT_W'(POOL_DEPTH - 1)) begin
								hw_q    <= hw_q + SLOT_W'(1);
								state_q <= S_INS;
							end else state_q <= S_DONE;
						end
						CMD_REMOVE: state_q <= (hit_q != '0) ? S_REM1 : S_DONE;
						default:    state_q <= S_DONE;
					endcase
				end
				S_FRD:  state_q <= S_FWT;
				S_FWT: begin
					free_head_q <= link_rd_q;
					state_q     <= S_INS;
				end
				S_INS:  state_q <= S_DONE;
				S_REM1: state_q <= S_REM2;
				S_REM2: begin
					free_head_q <= hit_q;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					// hold until the previous result has been taken
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				cmd_q <= cmd_t'(cmd);
				key_q <= key;
			end
			S_HASH: if (hash_done) b_q <= hash_bucket;
			S_HWT: begin
				head_q <= hv_q[b_q] ? head_rd_q : '0;
				idx_q  <= hv_q[b_q] ? head_rd_q : '0;
				prev_q <= '0;
				hit_q  <= '0;
			end
			S_NCMP: begin
				if (key_rd_q == key_q) begin
					hit_q     <= idx_q;
					hitlink_q <= link_rd_q;
				end else begin
					prev_q <= idx_q;
					idx_q  <= link_rd_q;
				end
			end
			S_ACT: begin
				res_slot_q   <= hit_q;
				res_found_q  <= (hit_q != '0);
				res_status_q <= ST_OK;
				priority case (cmd_q)
					CMD_INSERT: begin
						if (hit_q != '0) res_status_q <= ST_DUP;
						else if (free_head_q != '0) fresh_q <= free_head_q;
						else if (hw_q != SLOT_W'(POOL_DEPTH - 1)) fresh_q <= hw_q + SLOT_W'(1);
						else res_status_q <= ST_FULL;
					end
					CMD_REMOVE: if (hit_q == '0) res_status_q <= ST_ABSENT;
					default: ;
				endcase
			end
			S_INS: res_slot_q <= fresh_q;
			S_DONE: if (!out_valid_q || out_ready) begin
				out_slot_q   <= res_slot_q;
				out_found_q  <= res_found_q;
				out_status_q <= res_status_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign slot      = out_slot_q;
	assign found     = out_found_q;
	assign status    = out_status_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request accepted while busy");

	a_dup_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_DUP) |-> (found && slot != '0))
		else $error("duplicate insert without an existing node");

	a_fresh_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> (fresh_q != '0))
		else $error("insert into node zero");
endmodule
`default_nettype wire

@@ rtl/chs_hash.sv @@
// ----------------------------------------------------------------------------
// chs_hash: multiplicative hash and bucket reduction
// One 32x32 multiplier used twice for the low 64 product bits, then a
// restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_hash
	import chs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [KEY_W-1:0]   key,
	input  wire logic [CNT_W-1:0]   divisor,
	output logic                    done,
	output logic [BKT_W-1:0]        bucket
);
	typedef enum logic [3:0] {
		H_IDLE = 4'b0001,
		H_LO   = 4'b0010,
		H_HI   = 4'b0100,
		H_DIV  = 4'b1000
	} hphase_t;

	hphase_t          phase_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] prod_q;
	logic [5:0]       cnt_q;
	logic [CNT_W-1:0] rem_q;
	logic [31:0]      mul_a;
	logic [63:0]      mul_p;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic [CNT_W-1:0] rem_next;

	assign mul_a = (phase_q == H_HI) ? key_q[63:32] : key_q[31:0];
	assign mul_p = {32'd0, mul_a} * {32'd0, HASH_MUL};

	assign trial    = {rem_q, prod_q[KEY_W-1]};
	assign diff     = trial - {1'b0, divisor};
	assign rem_next = (trial >= {1'b0, divisor}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

	assign done   = (phase_q == H_DIV) && (cnt_q == 6'd0);
	assign bucket = rem_next[BKT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= H_IDLE;
		end else begin
			unique case (phase_q)
				H_IDLE: if (start) phase_q <= H_LO;
				H_LO:   phase_q <= H_HI;
				H_HI:   phase_q <= H_DIV;
				H_DIV:  if (cnt_q == 6'd0) phase_q <= H_IDLE;
				default: phase_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			H_IDLE: if (start) key_q <= key;
			H_LO:   prod_q <= mul_p;
			H_HI: begin
				// only the low half of the upper partial product lands in range
				prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
				cnt_q         <= 6'd63;
				rem_q         <= '0;
			end
			H_DIV: begin
				rem_q  <= rem_next;
				prod_q <= {prod_q[KEY_W-2:0], 1'b0};
				cnt_q  <= cnt_q - 6'd1;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
